### src/hpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpc_pkg;

  // ring size limits and field widths
  localparam int W           = 32;
  localparam int MAX_ORDER   = 32;
  localparam int LANES       = MAX_ORDER;
  localparam int ORDER_W     = 6;
  localparam int CNT_W       = 6;
  localparam int RESET_ORDER = 12;

  typedef logic [W-1:0]                 word_t;
  typedef logic [2*W-1:0]               dword_t;
  typedef logic [ORDER_W-1:0]           order_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [LANES-1:0][CNT_W-1:0]  cnt_vec_t;
  typedef logic [LANES-1:0]             lane_t;

  // per-stage advance enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // population count as four byte sums then one final add
  function automatic cnt_t popcnt(input word_t x);
    logic [3:0] part [4];
    cnt_t       sum;
    for (int k = 0; k < 4; k++) begin
      part[k] = '0;
      for (int j = 0; j < 8; j++) begin
        part[k] = part[k] + 4'(x[8*k+j]);
      end
    end
    sum = CNT_W'(part[0]) + CNT_W'(part[1]) + CNT_W'(part[2]) + CNT_W'(part[3]);
    return sum;
  endfunction

endpackage

`default_nettype wire

### src/hpc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hpc_front import hpc_pkg::*; (
  input  wire        clk,
  input  stage_en_t  en,
  input  order_t     ring_order,
  input  word_t      set_a,
  input  word_t      set_b,
  output dword_t     za,
  output dword_t     zb,
  output dword_t     zr,
  output word_t      mask
);

  function automatic word_t bit_rev(input word_t x);
    word_t y;
    for (int k = 0; k < W; k++) begin
      y[k] = x[W-1-k];
    end
    return y;
  endfunction

  // stage 1: clamp the ring order and mask both sets
  order_t n_nxt, n1_r;
  word_t  mask_nxt, mask1_r;
  word_t  a_nxt, a1_r;
  word_t  b_nxt, b1_r;

  always_comb begin
    if (ring_order == '0) begin
      n_nxt = ORDER_W'(1);
    end else if (ring_order > ORDER_W'(MAX_ORDER)) begin
      n_nxt = ORDER_W'(MAX_ORDER);
    end else begin
      n_nxt = ring_order;
    end
    if (n_nxt >= ORDER_W'(W)) begin
      mask_nxt = '1;
    end else begin
      mask_nxt = (word_t'(1) << n_nxt) - word_t'(1);
    end
    a_nxt = set_a & mask_nxt;
    b_nxt = set_b & mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      n1_r    <= n_nxt;
      mask1_r <= mask_nxt;
      a1_r    <= a_nxt;
      b1_r    <= b_nxt;
    end
  end

  // stage 2: double each set around the ring so every rotation is a fixed slice
  order_t shamt;
  word_t  refl;
  dword_t za_nxt, zb_nxt, zr_nxt;
  dword_t za_r, zb_r, zr_r;
  word_t  mask2_r;

  always_comb begin
    shamt  = ORDER_W'(W) - n1_r;
    refl   = bit_rev(b1_r) >> shamt;
    za_nxt = {a1_r, word_t'(0)} | (dword_t'(a1_r) << shamt);
    zb_nxt = {b1_r, word_t'(0)} | (dword_t'(b1_r) << shamt);
    zr_nxt = {refl, word_t'(0)} | (dword_t'(refl) << shamt);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      za_r    <= za_nxt;
      zb_r    <= zb_nxt;
      zr_r    <= zr_nxt;
      mask2_r <= mask1_r;
    end
  end

  assign za   = za_r;
  assign zb   = zb_r;
  assign zr   = zr_r;
  assign mask = mask2_r;

endmodule

`default_nettype wire

### src/hpc_lanes.sv
`timescale 1ns / 1ps
`default_nettype none

module hpc_lanes import hpc_pkg::*; (
  input  wire        clk,
  input  stage_en_t  en,
  input  dword_t     za,
  input  dword_t     zb,
  input  dword_t     zr,
  input  word_t      mask,
  output cnt_vec_t   cnt_a,
  output cnt_vec_t   cnt_b,
  output lane_t      hit,
  output word_t      mask_out,
  output logic       ident
);

  word_t    a_w, b_w;
  cnt_vec_t cnt_a_nxt, cnt_b_nxt, cnt_a_r, cnt_b_r;
  lane_t    hit_nxt, hit_r;
  word_t    mask_r;
  logic     ident_nxt, ident_r;

  assign a_w = za[2*W-1:W];
  assign b_w = zb[2*W-1:W];

  // one lane per distance: rotate, count self-overlap, match rotations and reflected rotations
  for (genvar d = 0; d < LANES; d++) begin : g_lane
    word_t rot_a, rot_b, rot_r;
    assign rot_a = za[W-d +: W] & mask;
    assign rot_b = zb[W-d +: W] & mask;
    assign rot_r = zr[W-d +: W] & mask;
    assign cnt_a_nxt[d] = popcnt(a_w & rot_a);
    assign cnt_b_nxt[d] = popcnt(b_w & rot_b);
    assign hit_nxt[d]   = (a_w == rot_b) || (a_w == rot_r);
  end

  assign ident_nxt = (a_w == b_w);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      hit_r   <= hit_nxt;
      mask_r  <= mask;
      ident_r <= ident_nxt;
    end
  end

  assign cnt_a    = cnt_a_r;
  assign cnt_b    = cnt_b_r;
  assign hit      = hit_r;
  assign mask_out = mask_r;
  assign ident    = ident_r;

endmodule

`default_nettype wire

### src/hpc_reduce.sv
`timescale 1ns / 1ps
`default_nettype none

module hpc_reduce import hpc_pkg::*; (
  input  wire        clk,
  input  stage_en_t  en,
  input  cnt_vec_t   cnt_a,
  input  cnt_vec_t   cnt_b,
  input  lane_t      hit,
  input  word_t      mask,
  input  logic       ident,
  output logic       same_iv,
  output logic       ident_out,
  output logic       dih,
  output logic       homo
);

  lane_t eq;
  logic  same_nxt, dih_nxt;
  logic  same_r, ident_r, dih_r, homo_r;

  // only distances below the ring order take part (mask bit d set iff d < n)
  for (genvar d = 0; d < LANES; d++) begin : g_eq
    assign eq[d] = (cnt_a[d] == cnt_b[d]) || !mask[d];
  end

  assign same_nxt = &eq;
  assign dih_nxt  = |(hit & mask);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      same_r  <= same_nxt;
      ident_r <= ident;
      dih_r   <= dih_nxt;
      homo_r  <= same_nxt && !dih_nxt;
    end
  end

  assign same_iv   = same_r;
  assign ident_out = ident_r;
  assign dih       = dih_r;
  assign homo      = homo_r;

endmodule

`default_nettype wire

### src/homometry_pair_check_core.sv
// Pairwise homometry check over the cyclic group Z_n.
// Input channel: in_valid / in_stall with set_a and set_b, 32-bit masks,
// bit i meaning element i; bits at or above the ring order are ignored.
// Output channel: out_valid / out_stall with four flags: equal interval
// vectors, identical sets, dihedral relation and homometric.
// Config: cfg_we writes cfg_wdata into the ring order; 0 acts as 1 and
// values above 32 act as 32. Write it only while the pipeline is empty.
// Throughput: one beat per cycle while out_stall is low. A beat passes
// through four register stages: order clamp and masking, ring doubling
// shifters, per-distance popcount and rotation-match lanes, and the final
// reduction which is also the output register.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up; in_stall rises only when all four stages hold beats
// and the receiver stalls. A stalled output beat holds steady.
// Reset (synchronous, rst_n low) empties the pipeline and sets the ring
// order to 12.
`timescale 1ns / 1ps
`default_nettype none

module homometry_pair_check_core import hpc_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [5:0]  cfg_wdata,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] in_set_a,
  input  wire  [31:0] in_set_b,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_same_interval_vector,
  output logic        out_identical_sets,
  output logic        out_dihedral_related,
  output logic        out_homometric
);

  // ring order register
  order_t ring_order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_order_r <= ORDER_W'(RESET_ORDER);
    end else if (cfg_we) begin
      ring_order_r <= cfg_wdata;
    end
  end

  // stage valids and advance enables
  logic      v1_r, v2_r, v3_r, v4_r;
  logic      v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  stage_en_t en;

  always_comb begin
    en.s4 = !v4_r || !out_stall;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
    v1_nxt = en.s1 ? in_valid : v1_r;
    v2_nxt = en.s2 ? v1_r     : v2_r;
    v3_nxt = en.s3 ? v2_r     : v3_r;
    v4_nxt = en.s4 ? v3_r     : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  assign in_stall  = !en.s1;
  assign out_valid = v4_r;

  // datapath
  dword_t   za, zb, zr;
  word_t    mask2, mask3;
  cnt_vec_t cnt_a, cnt_b;
  lane_t    hit;
  logic     ident3;

  hpc_front u_front (
    .clk        (clk),
    .en         (en),
    .ring_order (ring_order_r),
    .set_a      (in_set_a),
    .set_b      (in_set_b),
    .za         (za),
    .zb         (zb),
    .zr         (zr),
    .mask       (mask2)
  );

  hpc_lanes u_lanes (
    .clk      (clk),
    .en       (en),
    .za       (za),
    .zb       (zb),
    .zr       (zr),
    .mask     (mask2),
    .cnt_a    (cnt_a),
    .cnt_b    (cnt_b),
    .hit      (hit),
    .mask_out (mask3),
    .ident    (ident3)
  );

  hpc_reduce u_reduce (
    .clk       (clk),
    .en        (en),
    .cnt_a     (cnt_a),
    .cnt_b     (cnt_b),
    .hit       (hit),
    .mask      (mask3),
    .ident     (ident3),
    .same_iv   (out_same_interval_vector),
    .ident_out (out_identical_sets),
    .dih       (out_dihedral_related),
    .homo      (out_homometric)
  );

endmodule

`default_nettype wire

### dv/tb_homometry_pair_check_core.sv
`timescale 1ns / 1ps

module tb_homometry_pair_check_core;
  import hpc_pkg::*;

  localparam int NUM_PHASES       = 16;
  localparam int RANDOM_PER_PHASE = 108;
  localparam int CALM_PHASE       = 7;
  localparam int HOLD_CYCLES      = 60;
  localparam int DRAIN_CYCLES     = 8;
  localparam int IDLE_PCT         = 16;

  // the two all-interval tetrachords of Z_12: {0,1,4,6} and {0,1,3,7}
  localparam word_t TETRA_A = 32'h0000_0053;
  localparam word_t TETRA_B = 32'h0000_008B;

  typedef struct {
    word_t set_a;
    word_t set_b;
  } pair_t;

  typedef struct {
    int     idx;
    order_t ord;
    word_t  set_a;
    word_t  set_b;
    logic   same_iv;
    logic   ident;
    logic   dihedral;
    logic   homo;
  } verdict_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [5:0] cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  word_t      in_set_a  = '0;
  word_t      in_set_b  = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_same_interval_vector;
  logic       out_identical_sets;
  logic       out_dihedral_related;
  logic       out_homometric;

  // pairs waiting to be driven, and flags waiting to come back
  pair_t    pending[$];
  verdict_t awaited[$];

  order_t ring_order_mirror = order_t'(RESET_ORDER);
  order_t phase_order [NUM_PHASES];
  logic   in_beat_taken = 1'b0;
  logic   calm          = 1'b0;
  int     items_sent    = 0;
  int     items_taken   = 0;
  int     results_seen  = 0;
  int     error_count   = 0;
  int     stall_cycles  = 0;
  int     same_iv_seen  = 0;
  int     dihedral_seen = 0;
  int     homo_seen     = 0;
  int     hold_req      = 0;
  int     hold_seen     = 0;
  int     hold_cnt      = 0;

  homometry_pair_check_core dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_we                   (cfg_we),
    .cfg_wdata                (cfg_wdata),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_set_a                 (in_set_a),
    .in_set_b                 (in_set_b),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_same_interval_vector (out_same_interval_vector),
    .out_identical_sets       (out_identical_sets),
    .out_dihedral_related     (out_dihedral_related),
    .out_homometric           (out_homometric)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // zero acts as one, anything past the lane count saturates
  function automatic int live_order(order_t ord);
    if (ord == 0) return 1;
    if (ord > MAX_ORDER) return MAX_ORDER;
    return int'(ord);
  endfunction

  function automatic word_t low_bits(word_t x, int n);
    word_t m;
    m = (n >= W) ? '1 : ((word_t'(1) << n) - word_t'(1));
    return x & m;
  endfunction

  // b[j] = x[j-p mod n], so b is x rotated by p
  function automatic word_t spin(word_t x, int n, int p);
    word_t r;
    r = '0;
    for (int j = 0; j < n; j++) r[j] = x[(j + n - p) % n];
    return r;
  endfunction

  // b[j] = x[p-j mod n], a reflected rotation
  function automatic word_t mirror(word_t x, int n, int p);
    word_t r;
    r = '0;
    for (int j = 0; j < n; j++) r[j] = x[(p + n - j) % n];
    return r;
  endfunction

  // flags for one pair under the given ring order
  function automatic verdict_t judge_pair(order_t ord, word_t a_raw, word_t b_raw);
    verdict_t v;
    int       n;
    int       cnt_a;
    int       cnt_b;
    word_t    a;
    word_t    b;
    logic     rot_ok;
    logic     ref_ok;
    n = live_order(ord);
    a = low_bits(a_raw, n);
    b = low_bits(b_raw, n);
    v.ord = ord;
    v.set_a = a_raw;
    v.set_b = b_raw;
    // interval vectors, one distance at a time
    v.same_iv = 1'b1;
    for (int d = 0; d < n; d++) begin
      cnt_a = 0;
      cnt_b = 0;
      for (int i = 0; i < n; i++) begin
        cnt_a += int'(a[i] & a[(i + n - d) % n]);
        cnt_b += int'(b[i] & b[(i + n - d) % n]);
      end
      if (cnt_a != cnt_b) v.same_iv = 1'b0;
    end
    v.ident = (a == b);
    // any rotation or reflected rotation that maps b onto a
    v.dihedral = 1'b0;
    for (int p = 0; p < n; p++) begin
      rot_ok = 1'b1;
      ref_ok = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (a[i] != b[(i + p) % n]) rot_ok = 1'b0;
        if (a[i] != b[(p + n - i) % n]) ref_ok = 1'b0;
      end
      if (rot_ok || ref_ok) v.dihedral = 1'b1;
    end
    v.homo = v.same_iv && !v.dihedral;
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("MISMATCH: %s", msg);
  endtask

  task automatic check_flag(string field, logic got, logic want, verdict_t v);
    if (got !== want)
      report_mismatch($sformatf("pair %0d order %0d a=%h b=%h: %s got %b want %b",
                                v.idx, v.ord, v.set_a, v.set_b, field, got, want));
  endtask

  task automatic queue_pair(word_t a, word_t b);
    pair_t pr;
    pr.set_a = a;
    pr.set_b = b;
    pending.push_back(pr);
    items_sent++;
  endtask

  // mostly related pairs with random content, the rest noise
  task automatic make_random_pair(input int n, output word_t a, output word_t b);
    word_t hi_a;
    word_t hi_b;
    word_t ring;
    int    pick;
    int    p;
    hi_a = $urandom;
    hi_b = $urandom;
    ring = low_bits('1, n);
    a = $urandom;
    if ($urandom_range(3) == 0) a = a & word_t'($urandom) & word_t'($urandom);
    p = $urandom_range(n - 1);
    pick = $urandom_range(99);
    if (pick < 30) begin
      b = spin(a, n, p);
    end else if (pick < 50) begin
      b = mirror(a, n, p);
    end else if (pick < 65) begin
      if (n == 12) begin
        a = spin(TETRA_A, 12, $urandom_range(11));
        b = $urandom_range(1) ? spin(TETRA_B, 12, p) : mirror(TETRA_B, 12, p);
      end else begin
        // near miss: one member moved in or out
        b = low_bits(a, n) ^ (word_t'(1) << $urandom_range(n - 1));
      end
    end else if (pick < 75) begin
      b = a;
    end else begin
      b = $urandom;
    end
    // fresh don't-care bits above the ring
    if (pick < 75) begin
      a = low_bits(a, n) | (hi_a & ~ring);
      b = low_bits(b, n) | (hi_b & ~ring);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (items_taken != items_sent || results_seen != items_sent);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // input driver: hold a stalled beat, otherwise maybe offer the next one
  always @(negedge clk) begin
    pair_t nxt;
    if (rst_n && !(in_valid && !in_beat_taken)) begin
      if (pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pending.pop_front();
        in_valid <= 1'b1;
        in_set_a <= nxt.set_a;
        in_set_b <= nxt.set_b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // monitor: predict on input beats, compare on output beats
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      in_beat_taken <= 1'b0;
    end else begin
      in_beat_taken <= in_valid && !in_stall;
      if (in_valid && in_stall) stall_cycles++;
      if (in_valid && !in_stall) begin
        want = judge_pair(ring_order_mirror, in_set_a, in_set_b);
        want.idx = items_taken;
        awaited.push_back(want);
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (awaited.size() == 0) begin
          report_mismatch("result beat with no pair waiting for it");
        end else begin
          want = awaited.pop_front();
          same_iv_seen += int'(want.same_iv);
          dihedral_seen += int'(want.dihedral);
          homo_seen += int'(want.homo);
          check_flag("same_interval_vector", out_same_interval_vector, want.same_iv, want);
          check_flag("identical_sets", out_identical_sets, want.ident, want);
          check_flag("dihedral_related", out_dihedral_related, want.dihedral, want);
          check_flag("homometric", out_homometric, want.homo, want);
        end
      end
    end
  end

  // stimulus and phase control
  initial begin
    int    n;
    word_t a;
    word_t b;
    phase_order = '{6'd12, 6'd0, 6'd1, 6'd2, 6'd3, 6'd5, 6'd8, 6'd12,
                    6'd16, 6'd24, 6'd31, 6'd32, 6'd33, 6'd63, 6'd0, 6'd12};
    phase_order[14] = order_t'($urandom_range(1, 63));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pairs at the reset order of 12
    queue_pair(32'h0000_0000, 32'h0000_0000);
    queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_pair(32'hFFFF_FFFF, 32'h0000_0FFF);
    queue_pair(32'hFFFF_F000, 32'h0000_0000);
    queue_pair(32'h0000_0001, 32'h0000_0800);
    queue_pair(TETRA_A, TETRA_B);
    queue_pair(TETRA_A, spin(TETRA_B, 12, 5));
    queue_pair(TETRA_B, mirror(TETRA_A, 12, 7));
    queue_pair(TETRA_A, mirror(TETRA_A, 12, 3));
    queue_pair(TETRA_A, TETRA_A | 32'hABC0_0000);
    queue_pair(32'h5555_5555, 32'hAAAA_AAAA);
    queue_pair(32'h0000_000F, 32'h0000_00F0);
    queue_pair(32'h0000_0007, 32'h0000_000B);
    queue_pair(32'h0000_0001, 32'h0000_0003);
    queue_pair(32'h0000_0FFF, 32'h0000_0FFE);
    queue_pair(32'h8000_0000, 32'h0000_0001);
    queue_pair(32'h0000_000B, 32'h0000_000D);
    queue_pair(32'h0000_0249, 32'h0000_0492);
    queue_pair(32'h0000_0FFF, 32'h0000_0000);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // new ring order only once the pipeline is empty
      if (ph > 0) begin
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= phase_order[ph];
        ring_order_mirror = phase_order[ph];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
      end
      calm = (ph == CALM_PHASE);
      n = live_order(ring_order_mirror);
      queue_pair(32'h0000_0000, 32'h0000_0000);
      queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
      repeat (RANDOM_PER_PHASE) begin
        make_random_pair(n, a, b);
        queue_pair(a, b);
      end
      // long receiver hold-off while the queue is full
      if (ph % 5 == 2) hold_req = hold_req + 1;
    end

    wait_drained();
    if (awaited.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited.size()));
    $display("ran %0d pairs over %0d ring orders: %0d equal vectors, %0d dihedral, %0d homometric",
             items_taken, NUM_PHASES, same_iv_seen, dihedral_seen, homo_seen);
    $display("input held back on %0d cycles, %0d mismatches", stall_cycles, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout: %0d of %0d results seen", results_seen, items_sent);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### homometry_pair_check_core.f
src/hpc_pkg.sv
src/hpc_front.sv
src/hpc_lanes.sv
src/hpc_reduce.sv
src/homometry_pair_check_core.sv
dv/tb_homometry_pair_check_core.sv
